FILE: src/servo_reply_frame_parser_macros.svh
// ---------------------------------------------------------------------------
// Servo reply frame parser assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SERVO_REPLY_FRAME_PARSER_MACROS_SVH
`define SERVO_REPLY_FRAME_PARSER_MACROS_SVH

// Same-cycle implication.
`define SRFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SRFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/srfp_pkg.sv
// ---------------------------------------------------------------------------
// Servo reply frame parser package
// Shared types, codes and protocol constants of the reply frame parser.
// ---------------------------------------------------------------------------
package srfp_pkg;

   // Action codes carried with each input word.
   localparam logic [2:0] ACT_FRAME         = 3'd0;
   localparam logic [2:0] ACT_CLEAR_MODE    = 3'd1;
   localparam logic [2:0] ACT_CLEAR_TIMEOUT = 3'd2;
   localparam logic [2:0] ACT_CLEAR_ALL     = 3'd3;
   localparam logic [2:0] ACT_VERSION_REQ   = 3'd4;

   // Kind of frame taken, reported with each result word.
   localparam logic [2:0] KIND_NONE      = 3'd0;
   localparam logic [2:0] KIND_CONFIG    = 3'd1;
   localparam logic [2:0] KIND_FAULT     = 3'd2;
   localparam logic [2:0] KIND_VERSION   = 3'd3;
   localparam logic [2:0] KIND_TELEMETRY = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MOTOR_ID       = 2'd0;
   localparam logic [1:0] CSR_HOST_ID        = 2'd1;
   localparam logic [1:0] CSR_LEGACY_TIMEOUT = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT_TICKS  = 2'd3;

   // Frame types from identifier bits 28:24.
   localparam logic [4:0] TYPE_TELEMETRY   = 5'd2;
   localparam logic [4:0] TYPE_LEGACY_READ = 5'd9;
   localparam logic [4:0] TYPE_PARAM_READ  = 5'd17;
   localparam logic [4:0] TYPE_FAULT       = 5'd21;

   // Parameter indexes and payload signatures.
   localparam logic [15:0] IDX_MODE           = 16'h7005;
   localparam logic [15:0] IDX_TIMEOUT        = 16'h7028;
   localparam logic [15:0] IDX_LEGACY_TIMEOUT = 16'h200C;
   localparam logic [7:0]  LEGACY_IDX_LO      = 8'h0C;
   localparam logic [7:0]  LEGACY_IDX_HI      = 8'h20;
   localparam logic [7:0]  LEGACY_LEN_OK      = 8'h04;
   localparam logic [7:0]  VERSION_SIG_1      = 8'hC4;
   localparam logic [7:0]  VERSION_SIG_2      = 8'h56;
   localparam logic [6:0]  FRAME_BYTES        = 7'd8;
   localparam logic [1:0]  MODE_INVALID       = 2'd3;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] frame_id;
      logic        is_extended;
      logic        is_remote;
      logic        is_fd;
      logic [6:0]  length;
      logic [63:0] payload;
   } item_type;

   typedef struct packed {
      logic [7:0]  motor_id;
      logic [7:0]  host_id;
      logic        legacy_timeout;
      logic [16:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        mode_ok;
      logic        timeout_ok;
      logic [15:0] rejected_store;
      logic        version_waiting;
      logic [31:0] fault_store;
      logic [31:0] warning_store;
      logic [31:0] version_store;
      logic [63:0] telemetry_store;
      logic [1:0]  mode_store;
      logic [5:0]  fault_flag_store;
   } state_type;

endpackage

FILE: src/srfp_decode.sv
// ---------------------------------------------------------------------------
// Servo reply frame decoder
// Filters one registered word and computes the next parser state and kind.
// ---------------------------------------------------------------------------
module srfp_decode (
   input  srfp_pkg::item_type  item,
   input  srfp_pkg::cfg_type   cfg,
   input  srfp_pkg::state_type state_cur,
   output srfp_pkg::state_type state_next,
   output logic [2:0]          kind
);
   import srfp_pkg::*;

   logic [7:0][7:0] pb;
   logic [4:0]      frame_type;
   logic [7:0]      resp;
   logic [15:0]     index;
   logic            frame_ok;
   logic            ticks_match;

   assign pb         = item.payload;
   assign frame_type = item.frame_id[28:24];
   assign resp       = item.frame_id[23:16];
   assign index      = {pb[1], pb[0]};

   // Physical and addressing filter common to every frame type.
   assign frame_ok = item.is_extended && !item.is_remote && !item.is_fd &&
                     (item.length == FRAME_BYTES) && (item.frame_id[31:29] == 3'd0) &&
                     (item.frame_id[15:8] == cfg.motor_id) &&
                     (item.frame_id[7:0] == cfg.host_id);

   // Timeout value in bytes 7..4, little-endian; a zero setting never matches.
   assign ticks_match = (cfg.timeout_ticks != 17'd0) &&
                        (item.payload[63:32] == {15'd0, cfg.timeout_ticks});

   always_comb begin
      state_next = state_cur;
      kind       = KIND_NONE;
      unique case (item.action)
         ACT_FRAME: begin
            if (frame_ok) begin
               priority if (frame_type == TYPE_PARAM_READ) begin
                  if (resp <= 8'd1 && pb[2] == 8'd0 && pb[3] == 8'd0 &&
                      (index == IDX_MODE ||
                       (index == IDX_TIMEOUT && !cfg.legacy_timeout))) begin
                     kind = KIND_CONFIG;
                     if (resp == 8'd1) begin
                        state_next.rejected_store = index;
                     end else if (index == IDX_MODE) begin
                        state_next.mode_ok = (pb[4] == 8'd0);
                     end else begin
                        state_next.timeout_ok = ticks_match;
                     end
                  end
               end else if (frame_type == TYPE_LEGACY_READ && cfg.legacy_timeout) begin
                  if (resp <= 8'd1 && pb[0] == LEGACY_IDX_LO && pb[1] == LEGACY_IDX_HI &&
                      pb[3] == 8'd0) begin
                     if (resp == 8'd1) begin
                        state_next.rejected_store = IDX_LEGACY_TIMEOUT;
                        kind = KIND_CONFIG;
                     end else if (pb[2] == LEGACY_LEN_OK) begin
                        state_next.timeout_ok = ticks_match;
                        kind = KIND_CONFIG;
                     end
                  end
               end else if (frame_type == TYPE_FAULT) begin
                  if (resp == 8'd0) begin
                     state_next.fault_store   = item.payload[31:0];
                     state_next.warning_store = item.payload[63:32];
                     kind = KIND_FAULT;
                  end
               end else if (frame_type == TYPE_TELEMETRY) begin
                  if (pb[0] == 8'd0 && pb[1] == VERSION_SIG_1 && pb[2] == VERSION_SIG_2) begin
                     // Version reply: only taken while a request is pending.
                     if (state_cur.version_waiting) begin
                        state_next.version_store   = {pb[3], pb[4], pb[5], pb[6]};
                        state_next.version_waiting = 1'b0;
                        kind = KIND_VERSION;
                     end
                  end else if (item.frame_id[23:22] != MODE_INVALID) begin
                     state_next.telemetry_store  = item.payload;
                     state_next.mode_store       = item.frame_id[23:22];
                     state_next.fault_flag_store = item.frame_id[21:16];
                     kind = KIND_TELEMETRY;
                  end
               end else begin
                  kind = KIND_NONE;
               end
            end
         end
         ACT_CLEAR_MODE: begin
            state_next.mode_ok = 1'b0;
         end
         ACT_CLEAR_TIMEOUT: begin
            state_next.timeout_ok = 1'b0;
         end
         ACT_CLEAR_ALL: begin
            state_next.mode_ok        = 1'b0;
            state_next.timeout_ok     = 1'b0;
            state_next.rejected_store = 16'd0;
         end
         ACT_VERSION_REQ: begin
            state_next.version_waiting = 1'b1;
         end
         default: begin
            state_next = state_cur;
         end
      endcase
   end

endmodule

FILE: src/servo_reply_frame_parser.sv
// ---------------------------------------------------------------------------
// Servo reply frame parser
// Filters and decodes extended CAN reply frames from a servo drive and reports
// the tracked confirmation, fault, version and telemetry state once per word.
// ---------------------------------------------------------------------------
// Pipeline: a word accepted into the input register is decoded into the result
// and state registers once the result register is free, and its result word is
// then offered until the receiver takes it.
// Throughput: one word per cycle while the receiver does not stall, set by the
// single decode stage. Reset: synchronous, active high; clears the pipeline
// valids, the configuration and kind registers and the whole tracked state to zero.
`include "servo_reply_frame_parser_macros.svh"

module servo_reply_frame_parser (
   input  logic        clock,
   input  logic        reset,
   // Configuration write port.
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data,
   // Input word channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_frame_id,
   input  logic        req_is_extended,
   input  logic        req_is_remote,
   input  logic        req_is_fd,
   input  logic [6:0]  req_length,
   input  logic [63:0] req_payload,
   // Result word channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_accepted_kind,
   output logic        rsp_config_confirmed,
   output logic [15:0] rsp_rejected_index,
   output logic [31:0] rsp_fault_details,
   output logic [31:0] rsp_warning_bits,
   output logic [31:0] rsp_version_word,
   output logic [15:0] rsp_position_code,
   output logic [15:0] rsp_velocity_code,
   output logic [15:0] rsp_torque_code,
   output logic [15:0] rsp_temperature_tenths,
   output logic [1:0]  rsp_drive_mode,
   output logic [5:0]  rsp_fault_bits
);
   import srfp_pkg::*;

   // Configuration registers.
   cfg_type   cfg_ff;
   cfg_type   cfg_in;

   // Input register stage.
   logic      s1_valid_ff;
   logic      s1_valid_in;
   item_type  s1_item_ff;
   item_type  s1_item_in;

   // Tracked state and result register.
   state_type state_ff;
   state_type state_in;
   state_type state_dec;
   logic [2:0] kind_dec;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [2:0] kind_ff;
   logic [2:0] kind_in;

   logic       req_take;
   logic       advance;

   // The decode stage moves forward whenever the result register is empty or
   // its word is being taken this cycle, so a waiting result never blocks
   // the input register from refilling once the result moves on.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MOTOR_ID:       cfg_in.motor_id       = csr_data[7:0];
            CSR_HOST_ID:        cfg_in.host_id        = csr_data[7:0];
            CSR_LEGACY_TIMEOUT: cfg_in.legacy_timeout = csr_data[0];
            CSR_TIMEOUT_TICKS:  cfg_in.timeout_ticks  = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_item_in.action      = req_action;
      s1_item_in.frame_id    = req_frame_id;
      s1_item_in.is_extended = req_is_extended;
      s1_item_in.is_remote   = req_is_remote;
      s1_item_in.is_fd       = req_is_fd;
      s1_item_in.length      = req_length;
      s1_item_in.payload     = req_payload;
   end

   assign s1_valid_in = req_take || (s1_valid_ff && !advance);

   srfp_decode u_decode (
      .item       (s1_item_ff),
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .state_next (state_dec),
      .kind       (kind_dec)
   );

   // State commits exactly when its word moves into the result register, so
   // the result fields can be read straight off the state registers.
   assign state_in     = advance ? state_dec : state_ff;
   assign kind_in      = advance ? kind_dec : kind_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         kind_ff      <= KIND_NONE;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         kind_ff      <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= s1_item_in;
      end
   end

   // Result word: kind of the word plus a view of the stored state. Telemetry
   // codes are big-endian byte pairs of the last telemetry payload.
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_accepted_kind      = kind_ff;
   assign rsp_config_confirmed   = (state_ff.rejected_store == 16'd0) &&
                                   state_ff.mode_ok && state_ff.timeout_ok;
   assign rsp_rejected_index     = state_ff.rejected_store;
   assign rsp_fault_details      = state_ff.fault_store;
   assign rsp_warning_bits       = state_ff.warning_store;
   assign rsp_version_word       = state_ff.version_store;
   assign rsp_position_code      = {state_ff.telemetry_store[7:0],
                                    state_ff.telemetry_store[15:8]};
   assign rsp_velocity_code      = {state_ff.telemetry_store[23:16],
                                    state_ff.telemetry_store[31:24]};
   assign rsp_torque_code        = {state_ff.telemetry_store[39:32],
                                    state_ff.telemetry_store[47:40]};
   assign rsp_temperature_tenths = {state_ff.telemetry_store[55:48],
                                    state_ff.telemetry_store[63:56]};
   assign rsp_drive_mode         = state_ff.mode_store;
   assign rsp_fault_bits         = state_ff.fault_flag_store;

   // The tracked state only moves when a word passes the decode stage.
   `SRFP_ASSERT_NEXT(a_state_holds, !advance, $stable(state_ff), "state changed without a word")
   // A version reply is only taken while a request is pending.
   `SRFP_ASSERT_NOW(a_version_pending, advance && kind_dec == KIND_VERSION,
      state_ff.version_waiting, "version taken with no request pending")
   // Non-frame actions never report a taken frame.
   `SRFP_ASSERT_NOW(a_action_kind, advance && s1_item_ff.action != ACT_FRAME,
      kind_dec == KIND_NONE, "non-frame action reported a frame kind")
   // The input side stalls only while the input register holds a word.
   `SRFP_ASSERT_NOW(a_stall_full, req_stall, s1_valid_ff, "stall with empty input register")

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// Servo reply frame parser testbench
// Drives reply frames and actions into the parser with random sender gaps and
// receiver stalls, predicts every status word in a model of its own, and
// compares each returned word field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import srfp_pkg::*;

   // Action and frame type outside the defined sets, and the largest 29-bit id.
   localparam logic [2:0]  ACT_UNUSED   = 3'd7;
   localparam logic [4:0]  TYPE_UNUSED  = 5'd31;
   localparam logic [31:0] MAX_EXT_ID   = 32'h1FFF_FFFF;
   localparam int          CHUNK_WORDS  = 45;
   localparam int          CHUNKS       = 9;
   localparam int          HOLD_CYCLES  = 60;
   localparam int          TAIL_CYCLES  = 8;

   // One status word as the parser reports it.
   typedef struct packed {
      logic [2:0]  kind;
      logic        confirmed;
      logic [15:0] rejected;
      logic [31:0] fault;
      logic [31:0] warning;
      logic [31:0] version;
      logic [15:0] position;
      logic [15:0] velocity;
      logic [15:0] torque;
      logic [15:0] temperature;
      logic [1:0]  mode;
      logic [5:0]  fault_flags;
   } status_word_type;

   // A step of the directed part: either a register setting or one input word.
   // Where typed is set, the kind of the status word is written out by hand.
   typedef struct {
      logic       is_setting;
      cfg_type    setting;
      item_type   w;
      logic       typed;
      logic [2:0] kind;
   } plan_row_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_data  = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action      = '0;
   logic [31:0] req_frame_id    = '0;
   logic        req_is_extended = 1'b0;
   logic        req_is_remote   = 1'b0;
   logic        req_is_fd       = 1'b0;
   logic [6:0]  req_length      = '0;
   logic [63:0] req_payload     = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_accepted_kind;
   logic        rsp_config_confirmed;
   logic [15:0] rsp_rejected_index;
   logic [31:0] rsp_fault_details;
   logic [31:0] rsp_warning_bits;
   logic [31:0] rsp_version_word;
   logic [15:0] rsp_position_code;
   logic [15:0] rsp_velocity_code;
   logic [15:0] rsp_torque_code;
   logic [15:0] rsp_temperature_tenths;
   logic [1:0]  rsp_drive_mode;
   logic [5:0]  rsp_fault_bits;

   // Our own copy of the register settings and of the tracked state.
   cfg_type    drive_cfg = '0;
   state_type  tracked   = '0;

   status_word_type predicted_status [$];
   plan_row_type    directed_plan [$];
   status_word_type got_status;
   status_word_type want_status;
   int         mismatch_count = 0;
   int         tx_idle_pct = 26;
   int         rx_idle_pct = 61;
   int         hold_requests = 0;

   servo_reply_frame_parser u_top (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_action             (req_action),
      .req_frame_id           (req_frame_id),
      .req_is_extended        (req_is_extended),
      .req_is_remote          (req_is_remote),
      .req_is_fd              (req_is_fd),
      .req_length             (req_length),
      .req_payload            (req_payload),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_accepted_kind      (rsp_accepted_kind),
      .rsp_config_confirmed   (rsp_config_confirmed),
      .rsp_rejected_index     (rsp_rejected_index),
      .rsp_fault_details      (rsp_fault_details),
      .rsp_warning_bits       (rsp_warning_bits),
      .rsp_version_word       (rsp_version_word),
      .rsp_position_code      (rsp_position_code),
      .rsp_velocity_code      (rsp_velocity_code),
      .rsp_torque_code        (rsp_torque_code),
      .rsp_temperature_tenths (rsp_temperature_tenths),
      .rsp_drive_mode         (rsp_drive_mode),
      .rsp_fault_bits         (rsp_fault_bits)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the parser hangs or never drains.
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Timeout confirmation: a zero setting never confirms, otherwise bytes 7..4
   // read little-endian must equal the programmed tick count.
   function automatic logic ticks_match(logic [31:0] le_word);
      return drive_cfg.timeout_ticks != '0 && le_word == {15'd0, drive_cfg.timeout_ticks};
   endfunction

   // Applies one accepted word to the tracked state and returns the status word
   // that the parser should report for it.
   function automatic status_word_type parse_reply_frame(item_type w);
      status_word_type o;
      logic [7:0]  b [8];
      logic [7:0]  r;
      logic [4:0]  ftype;
      logic [15:0] pidx;
      logic        addr_ok;
      logic [63:0] tel;
      for (int k = 0; k < 8; k++) b[k] = w.payload[8*k +: 8];
      o = '0;
      o.kind = KIND_NONE;
      r = w.frame_id[23:16];
      ftype = w.frame_id[28:24];
      pidx = {b[1], b[0]};
      // Only clean 8-byte extended data frames addressed to us are decoded.
      addr_ok = w.is_extended && !w.is_remote && !w.is_fd && w.length == FRAME_BYTES &&
                w.frame_id <= MAX_EXT_ID && w.frame_id[15:8] == drive_cfg.motor_id &&
                w.frame_id[7:0] == drive_cfg.host_id;
      case (w.action)
         ACT_FRAME: begin
            if (!addr_ok) begin
               o.kind = KIND_NONE;
            end else if (ftype == TYPE_PARAM_READ) begin
               if (r <= 8'd1 && b[2] == 8'd0 && b[3] == 8'd0 &&
                   (pidx == IDX_MODE || (pidx == IDX_TIMEOUT && !drive_cfg.legacy_timeout))) begin
                  o.kind = KIND_CONFIG;
                  if (r == 8'd1)
                     tracked.rejected_store = pidx;
                  else if (pidx == IDX_MODE)
                     tracked.mode_ok = (b[4] == 8'd0);
                  else
                     tracked.timeout_ok = ticks_match(w.payload[63:32]);
               end
            end else if (ftype == TYPE_LEGACY_READ && drive_cfg.legacy_timeout) begin
               if (r <= 8'd1 && b[0] == LEGACY_IDX_LO && b[1] == LEGACY_IDX_HI &&
                   b[3] == 8'd0) begin
                  if (r == 8'd1) begin
                     tracked.rejected_store = IDX_LEGACY_TIMEOUT;
                     o.kind = KIND_CONFIG;
                  end else if (b[2] == LEGACY_LEN_OK) begin
                     tracked.timeout_ok = ticks_match(w.payload[63:32]);
                     o.kind = KIND_CONFIG;
                  end
               end
            end else if (ftype == TYPE_FAULT) begin
               if (r == 8'd0) begin
                  tracked.fault_store = w.payload[31:0];
                  tracked.warning_store = w.payload[63:32];
                  o.kind = KIND_FAULT;
               end
            end else if (ftype == TYPE_TELEMETRY) begin
               // A version signature is never telemetry, even when unsolicited.
               if (b[0] == 8'd0 && b[1] == VERSION_SIG_1 && b[2] == VERSION_SIG_2) begin
                  if (tracked.version_waiting) begin
                     tracked.version_store = {b[3], b[4], b[5], b[6]};
                     tracked.version_waiting = 1'b0;
                     o.kind = KIND_VERSION;
                  end
               end else if (w.frame_id[23:22] != MODE_INVALID) begin
                  tracked.telemetry_store = w.payload;
                  tracked.mode_store = w.frame_id[23:22];
                  tracked.fault_flag_store = w.frame_id[21:16];
                  o.kind = KIND_TELEMETRY;
               end
            end
         end
         ACT_CLEAR_MODE: tracked.mode_ok = 1'b0;
         ACT_CLEAR_TIMEOUT: tracked.timeout_ok = 1'b0;
         ACT_CLEAR_ALL: begin
            tracked.mode_ok = 1'b0;
            tracked.timeout_ok = 1'b0;
            tracked.rejected_store = '0;
         end
         ACT_VERSION_REQ: tracked.version_waiting = 1'b1;
         default: ;
      endcase
      tel = tracked.telemetry_store;
      o.confirmed = tracked.rejected_store == '0 && tracked.mode_ok && tracked.timeout_ok;
      o.rejected = tracked.rejected_store;
      o.fault = tracked.fault_store;
      o.warning = tracked.warning_store;
      o.version = tracked.version_store;
      // Telemetry halves are big-endian byte pairs of the stored payload.
      o.position = {tel[7:0], tel[15:8]};
      o.velocity = {tel[23:16], tel[31:24]};
      o.torque = {tel[39:32], tel[47:40]};
      o.temperature = {tel[55:48], tel[63:56]};
      o.mode = tracked.mode_store;
      o.fault_flags = tracked.fault_flag_store;
      return o;
   endfunction

   function automatic logic [31:0] reply_id(logic [4:0] t, logic [7:0] r, logic [7:0] m,
                                            logic [7:0] h);
      return {3'b000, t, r, m, h};
   endfunction

   // A frame that passes every format check; only the id and bytes decide.
   function automatic item_type frame_word(logic [31:0] id, logic [63:0] p);
      item_type w;
      w.action = ACT_FRAME;
      w.frame_id = id;
      w.is_extended = 1'b1;
      w.is_remote = 1'b0;
      w.is_fd = 1'b0;
      w.length = FRAME_BYTES;
      w.payload = p;
      return w;
   endfunction

   // A non-frame action carries junk in the frame fields, which must be ignored.
   function automatic item_type action_word(logic [2:0] a);
      item_type w;
      w.action = a;
      w.frame_id = $urandom;
      w.is_extended = 1'($urandom);
      w.is_remote = 1'($urandom);
      w.is_fd = 1'($urandom);
      w.length = 7'($urandom);
      w.payload = {$urandom, $urandom};
      return w;
   endfunction

   function automatic logic [7:0] edge_byte();
      if ($urandom_range(0, 2) == 0)
         return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom);
   endfunction

   function automatic cfg_type random_setting(int n);
      cfg_type c;
      c.motor_id = edge_byte();
      c.host_id = edge_byte();
      c.legacy_timeout = n[0];
      case ($urandom_range(0, 4))
         0: c.timeout_ticks = 17'd0;
         1: c.timeout_ticks = 17'd1;
         2: c.timeout_ticks = 17'd100000;
         3: c.timeout_ticks = 17'h1FFFF;
         default: c.timeout_ticks = 17'($urandom);
      endcase
      return c;
   endfunction

   // Mostly well-formed replies for the current addresses with random content,
   // mixed with actions and with noise frames that fail the format checks.
   function automatic item_type random_word();
      item_type w;
      logic [7:0]  r;
      logic [4:0]  t;
      logic [63:0] p;
      int          pick;
      pick = $urandom_range(0, 99);
      p = {$urandom, $urandom};
      if (pick < 15)
         return action_word($urandom_range(0, 99) < 40 ? ACT_VERSION_REQ :
                            3'($urandom_range(1, 7)));
      if (pick < 25) begin
         w = action_word(ACT_FRAME);
         w.action = ACT_FRAME;
         if ($urandom_range(0, 1))
            w.frame_id[15:0] = {drive_cfg.motor_id, drive_cfg.host_id};
         return w;
      end
      r = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0, 1: begin
            t = TYPE_PARAM_READ;
            case ($urandom_range(0, 4))
               0, 1: p[15:0] = IDX_MODE;
               2, 3: p[15:0] = IDX_TIMEOUT;
               default: ;
            endcase
            if ($urandom_range(0, 9) != 0) p[31:16] = '0;
            if ($urandom_range(0, 1))
               p[63:32] = {15'd0, drive_cfg.timeout_ticks};
            else if ($urandom_range(0, 1))
               p[39:32] = '0;
         end
         2: begin
            t = TYPE_LEGACY_READ;
            p[7:0] = LEGACY_IDX_LO;
            p[15:8] = LEGACY_IDX_HI;
            if ($urandom_range(0, 4) != 0) p[23:16] = LEGACY_LEN_OK;
            if ($urandom_range(0, 9) != 0) p[31:24] = '0;
            if ($urandom_range(0, 9) < 6) p[63:32] = {15'd0, drive_cfg.timeout_ticks};
         end
         3: t = TYPE_FAULT;
         4: begin
            t = TYPE_TELEMETRY;
            r = 8'($urandom);
            if ($urandom_range(0, 9) < 4) p[23:0] = {VERSION_SIG_2, VERSION_SIG_1, 8'h00};
         end
         default: t = 5'($urandom);
      endcase
      w = frame_word(reply_id(t, r, drive_cfg.motor_id, drive_cfg.host_id), p);
      if ($urandom_range(0, 19) == 0)
         w.frame_id[15:0] = w.frame_id[15:0] ^ (16'd1 << $urandom_range(0, 15));
      return w;
   endfunction

   task automatic add_row(item_type w, logic typed, logic [2:0] kind);
      plan_row_type row;
      row = '{default: '0};
      row.w = w;
      row.typed = typed;
      row.kind = kind;
      directed_plan.push_back(row);
   endtask

   task automatic add_setting(cfg_type c);
      plan_row_type row;
      row = '{default: '0};
      row.is_setting = 1'b1;
      row.setting = c;
      directed_plan.push_back(row);
   endtask

   // Registers change only with nothing in flight. Unused upper data bits carry
   // junk, since the parser must take only the register's width.
   task automatic apply_setting(cfg_type c);
      req_valid <= 1'b0;
      while (predicted_status.size() != 0) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_MOTOR_ID;
      csr_data <= {9'($urandom), c.motor_id};
      @(posedge clock);
      csr_index <= CSR_HOST_ID;
      csr_data <= {9'($urandom), c.host_id};
      @(posedge clock);
      csr_index <= CSR_LEGACY_TIMEOUT;
      csr_data <= {16'($urandom), c.legacy_timeout};
      @(posedge clock);
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_data <= c.timeout_ticks;
      @(posedge clock);
      csr_write <= 1'b0;
      drive_cfg = c;
   endtask

   // Offers one word, holding it steady until the parser takes it, then files
   // the predicted status word. A hand-typed kind overrides the predicted one.
   task automatic offer_word(item_type w, logic typed, logic [2:0] kind);
      status_word_type s;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= w.action;
      req_frame_id <= w.frame_id;
      req_is_extended <= w.is_extended;
      req_is_remote <= w.is_remote;
      req_is_fd <= w.is_fd;
      req_length <= w.length;
      req_payload <= w.payload;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      s = parse_reply_frame(w);
      if (typed) s.kind = kind;
      predicted_status.push_back(s);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request so that the
   // parser backs up and stalls its input while the sender keeps offering.
   initial begin : receiver
      int hold_served;
      int hold_cycles;
      hold_served = 0;
      hold_cycles = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_cycles = HOLD_CYCLES;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
         end
      end
   end

   // Every status word taken at an edge is compared with the oldest prediction.
   // Signals are read as they stood just before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_status = '{rsp_accepted_kind, rsp_config_confirmed, rsp_rejected_index,
                        rsp_fault_details, rsp_warning_bits, rsp_version_word,
                        rsp_position_code, rsp_velocity_code, rsp_torque_code,
                        rsp_temperature_tenths, rsp_drive_mode, rsp_fault_bits};
         if (predicted_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: status word with none predicted: %h", $realtime, got_status);
         end else begin
            want_status = predicted_status.pop_front();
            check_field("accepted_kind", 64'(want_status.kind), 64'(got_status.kind));
            check_field("config_confirmed", 64'(want_status.confirmed),
                        64'(got_status.confirmed));
            check_field("rejected_index", 64'(want_status.rejected),
                        64'(got_status.rejected));
            check_field("fault_details", 64'(want_status.fault), 64'(got_status.fault));
            check_field("warning_bits", 64'(want_status.warning), 64'(got_status.warning));
            check_field("version_word", 64'(want_status.version), 64'(got_status.version));
            check_field("position_code", 64'(want_status.position),
                        64'(got_status.position));
            check_field("velocity_code", 64'(want_status.velocity),
                        64'(got_status.velocity));
            check_field("torque_code", 64'(want_status.torque), 64'(got_status.torque));
            check_field("temperature_tenths", 64'(want_status.temperature),
                        64'(got_status.temperature));
            check_field("drive_mode", 64'(want_status.mode), 64'(got_status.mode));
            check_field("fault_bits", 64'(want_status.fault_flags),
                        64'(got_status.fault_flags));
         end
      end
   end

   initial begin : stimulus
      item_type w;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, first under the reset settings (both addresses zero,
      // modern timeout path, zero ticks).
      w = frame_word(reply_id(TYPE_PARAM_READ, 8'h00, 8'h00, 8'h00), {32'h0, 16'h0, IDX_MODE});
      add_row(w, 1'b1, KIND_CONFIG);
      // Each format check on its own drops the frame.
      w.is_extended = 1'b0;
      add_row(w, 1'b1, KIND_NONE);
      w.is_extended = 1'b1;
      w.is_remote = 1'b1;
      add_row(w, 1'b1, KIND_NONE);
      w.is_remote = 1'b0;
      w.is_fd = 1'b1;
      add_row(w, 1'b1, KIND_NONE);
      w.is_fd = 1'b0;
      w.length = 7'd64;
      add_row(w, 1'b1, KIND_NONE);
      // Identifier above the 29-bit range.
      w = frame_word(32'hE000_0000 | reply_id(TYPE_FAULT, 8'h00, 8'h00, 8'h00), '1);
      add_row(w, 1'b1, KIND_NONE);
      add_row(action_word(ACT_UNUSED), 1'b1, KIND_NONE);
      // A version reply counts only while one is requested, and only once.
      add_row(action_word(ACT_VERSION_REQ), 1'b1, KIND_NONE);
      w = frame_word(reply_id(TYPE_TELEMETRY, 8'h00, 8'h00, 8'h00),
                     {8'h9A, 8'h78, 8'h56, 8'h34, 8'h12, VERSION_SIG_2, VERSION_SIG_1, 8'h00});
      add_row(w, 1'b1, KIND_VERSION);
      add_row(w, 1'b1, KIND_NONE);
      w = frame_word(reply_id(TYPE_FAULT, 8'h00, 8'h00, 8'h00), '1);
      add_row(w, 1'b1, KIND_FAULT);
      w.frame_id = reply_id(TYPE_FAULT, 8'h01, 8'h00, 8'h00);
      add_row(w, 1'b1, KIND_NONE);
      // Telemetry with all fault flags set, then the invalid mode.
      w = frame_word(reply_id(TYPE_TELEMETRY, 8'hBF, 8'h00, 8'h00), '1);
      add_row(w, 1'b1, KIND_TELEMETRY);
      w.frame_id = reply_id(TYPE_TELEMETRY, 8'hC0, 8'h00, 8'h00);
      add_row(w, 1'b1, KIND_NONE);
      // Zero ticks: the timeout reply is taken but never confirms.
      w = frame_word(reply_id(TYPE_PARAM_READ, 8'h00, 8'h00, 8'h00),
                     {32'h0, 16'h0, IDX_TIMEOUT});
      add_row(w, 1'b1, KIND_CONFIG);

      add_setting('{motor_id: 8'hFF, host_id: 8'hFF, legacy_timeout: 1'b0,
                    timeout_ticks: 17'd100000});
      w = frame_word(reply_id(TYPE_PARAM_READ, 8'h00, 8'hFF, 8'hFF),
                     {32'd100000, 16'h0, IDX_TIMEOUT});
      add_row(w, 1'b0, KIND_NONE);
      w = frame_word(reply_id(TYPE_PARAM_READ, 8'h01, 8'hFF, 8'hFF), {32'h0, 16'h0, IDX_MODE});
      add_row(w, 1'b1, KIND_CONFIG);
      add_row(action_word(ACT_CLEAR_ALL), 1'b1, KIND_NONE);
      add_row(action_word(ACT_CLEAR_MODE), 1'b1, KIND_NONE);
      add_row(action_word(ACT_CLEAR_TIMEOUT), 1'b1, KIND_NONE);
      w = frame_word(reply_id(TYPE_FAULT, 8'h00, 8'hFE, 8'hFF), '0);
      add_row(w, 1'b1, KIND_NONE);

      // Legacy timeout path: type 9 replies count, index 0x7028 no longer does.
      add_setting('{motor_id: 8'h5A, host_id: 8'hA5, legacy_timeout: 1'b1,
                    timeout_ticks: 17'd1});
      w = frame_word(reply_id(TYPE_LEGACY_READ, 8'h00, 8'h5A, 8'hA5),
                     {32'd1, 8'h00, LEGACY_LEN_OK, LEGACY_IDX_HI, LEGACY_IDX_LO});
      add_row(w, 1'b0, KIND_NONE);
      w.frame_id = reply_id(TYPE_LEGACY_READ, 8'h01, 8'h5A, 8'hA5);
      add_row(w, 1'b1, KIND_CONFIG);
      w.frame_id = reply_id(TYPE_LEGACY_READ, 8'h00, 8'h5A, 8'hA5);
      w.payload[23:16] = 8'h05;
      add_row(w, 1'b1, KIND_NONE);
      w = frame_word(reply_id(TYPE_PARAM_READ, 8'h00, 8'h5A, 8'hA5),
                     {32'd1, 16'h0, IDX_TIMEOUT});
      add_row(w, 1'b1, KIND_NONE);
      w = frame_word(reply_id(TYPE_UNUSED, 8'h00, 8'h5A, 8'hA5), '1);
      add_row(w, 1'b1, KIND_NONE);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_setting)
            apply_setting(directed_plan[i].setting);
         else
            offer_word(directed_plan[i].w, directed_plan[i].typed, directed_plan[i].kind);
      end

      // Random part: a fresh setting per chunk. The first third idles the sender
      // lightly and the receiver heavily, the second the other way round, and
      // the last idles neither, opening with the long receiver hold-off.
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         apply_setting(random_setting(chunk));
         if (chunk < CHUNKS / 3) begin
            tx_idle_pct = 26;
            rx_idle_pct = 61;
         end else if (chunk < 2 * CHUNKS / 3) begin
            tx_idle_pct = 61;
            rx_idle_pct = 26;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         if (chunk == 2 * CHUNKS / 3) hold_requests++;
         repeat (CHUNK_WORDS) offer_word(random_word(), 1'b0, KIND_NONE);
      end

      req_valid <= 1'b0;
      while (predicted_status.size() != 0) @(posedge clock);
      // A short tail catches any status word beyond the predicted ones.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && predicted_status.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
